// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tpc_pkg.sv =====
package tpc_pkg;

  // Field widths
  localparam int ADC_W    = 14;
  localparam int COEFF_W  = 24;
  localparam int LIN_W    = 18;
  localparam int STRIP_W  = 12;
  localparam int WEIGHT_W = 7;
  localparam int NUM_TAPS = 5;
  localparam int CFG_INDEX_W = 3;

  localparam logic [LIN_W-1:0]   LIN_MAX   = 18'h3FFFF;
  localparam logic [STRIP_W-1:0] STRIP_MAX = 12'hFFF;

  // Result queue depth, default for the top level
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_4 = 3'd4;

  typedef struct packed {
    logic [ADC_W-1:0]   adc_word;
    logic [COEFF_W-1:0] coeff_gain1;
    logic [COEFF_W-1:0] coeff_gain2;
    logic [COEFF_W-1:0] coeff_gain3;
    logic               frame_end;
  } in_word_t;

  typedef struct packed {
    logic [LIN_W-1:0]   lin_value;
    logic [LIN_W-1:0]   filter_value;
    logic               peak_flag;
    logic [STRIP_W-1:0] strip_value;
    logic               frame_last;
  } out_word_t;

endpackage

// ===== hw/rtl/tpc_front.sv =====
module tpc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tpc_pkg::in_word_t                 in_data,
  input  logic                              cfg_valid,
  input  logic [tpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tpc_pkg::WEIGHT_W-1:0]      cfg_data,
  output logic                              push_valid,
  input  logic                              push_ready,
  output tpc_pkg::out_word_t                push_data
);
  import tpc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LIN    = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_SUM    = 7'b0001000,
    S_EMIT_A = 7'b0010000,
    S_EMIT_B = 7'b0100000,
    S_EMIT_C = 7'b1000000
  } front_state_t;

  front_state_t state, state_next;

  logic signed [WEIGHT_W-1:0] weights [NUM_TAPS];
  logic [LIN_W-1:0]           window [NUM_TAPS];
  logic [LIN_W-1:0]           hist [2];
  logic [2:0]                 pos;
  logic                       frame_end_r;
  logic [15:0]                diff;
  logic [7:0]                 mult;
  logic [3:0]                 shamt;
  logic signed [19:0]         terms [NUM_TAPS];
  logic [LIN_W-1:0]           fir_out;

  // Build one result word; strip value only at peaks
  function automatic out_word_t make_word(input logic [LIN_W-1:0] lin,
                                          input logic [LIN_W-1:0] filt,
                                          input logic peak, input logic last);
    out_word_t w;
    w.lin_value    = lin;
    w.filter_value = filt;
    w.peak_flag    = peak;
    w.strip_value  = !peak ? '0 :
                     (filt > LIN_W'(STRIP_MAX)) ? STRIP_MAX : filt[STRIP_W-1:0];
    w.frame_last   = last;
    return w;
  endfunction

  // Weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) weights[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT_0: weights[0] <= cfg_data;
        REG_WEIGHT_1: weights[1] <= cfg_data;
        REG_WEIGHT_2: weights[2] <= cfg_data;
        REG_WEIGHT_3: weights[3] <= cfg_data;
        REG_WEIGHT_4: weights[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gain select and base subtract on the accepted word
  logic [1:0]         gain;
  logic [COEFF_W-1:0] coeff_sel;
  always_comb begin
    gain = in_data.adc_word[13:12];
    case (gain)
      2'd1:    coeff_sel = in_data.coeff_gain1;
      2'd2:    coeff_sel = in_data.coeff_gain2;
      2'd3:    coeff_sel = in_data.coeff_gain3;
      default: coeff_sel = ((in_data.coeff_gain1[23:16] | in_data.coeff_gain2[23:16] |
                             in_data.coeff_gain3[23:16]) == 8'd0) ? 24'd0 : 24'hFF0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      diff        <= {4'd0, in_data.adc_word[11:0]} - {4'd0, coeff_sel[11:0]};
      shamt       <= coeff_sel[15:12];
      mult        <= coeff_sel[23:16];
      frame_end_r <= in_data.frame_end;
    end
  end

  // Linearizer: multiply, shift, clip
  logic [23:0] lin_prod;
  logic [23:0] lin_shifted;
  logic [LIN_W-1:0] lin_val;
  always_comb begin
    lin_prod    = 24'(diff) * 24'(mult);
    lin_shifted = lin_prod >> ({1'b0, shamt} + 5'd2);
    lin_val     = (lin_shifted > 24'(LIN_MAX)) ? LIN_MAX : lin_shifted[LIN_W-1:0];
  end

  // FIR taps, each floored by >>6
  logic signed [25:0] tap_prod [NUM_TAPS];
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++)
      tap_prod[i] = 26'(weights[i]) * 26'($signed({1'b0, window[i]}));
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      for (int i = 0; i < NUM_TAPS; i++) terms[i] <= tap_prod[i][25:6];
    end
  end

  // Sum of terms, clipped; zero before the window is full
  logic signed [22:0] tap_sum;
  always_comb begin
    tap_sum = '0;
    for (int i = 0; i < NUM_TAPS; i++) tap_sum = tap_sum + 23'(terms[i]);
  end

  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      if (pos < 3'd4 || tap_sum < 23'sd0) fir_out <= '0;
      else if (tap_sum > $signed({5'd0, LIN_MAX})) fir_out <= LIN_MAX;
      else fir_out <= tap_sum[LIN_W-1:0];
    end
  end

  // Result words
  logic peak_a, peak_b;
  out_word_t word_a, word_b, word_c;
  always_comb begin
    peak_a = (pos >= 3'd3) && (hist[1] > hist[0]) && (hist[1] > fir_out);
    peak_b = (pos >= 3'd2) && (fir_out > hist[1]) && (fir_out != '0);
    word_a = make_word(window[2], hist[1], peak_a, 1'b0);
    word_b = make_word(window[3], fir_out, peak_b, 1'b0);
    word_c = make_word(window[4], '0, 1'b0, 1'b1);
  end

  logic advance;
  always_comb begin
    push_valid = ((state == S_EMIT_A) && (pos >= 3'd2)) ||
                 ((state == S_EMIT_B) && (pos >= 3'd1)) ||
                 (state == S_EMIT_C);
    case (state)
      S_EMIT_A: push_data = word_a;
      S_EMIT_B: push_data = word_b;
      default:  push_data = word_c;
    endcase
    advance = !push_valid || push_ready;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_LIN;
      S_LIN:    state_next = S_MUL;
      S_MUL:    state_next = S_SUM;
      S_SUM:    state_next = S_EMIT_A;
      S_EMIT_A: if (advance) state_next = frame_end_r ? S_EMIT_B : S_IDLE;
      S_EMIT_B: if (advance) state_next = S_EMIT_C;
      S_EMIT_C: if (advance) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // Frame state: window, filter history, position
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_TAPS; i++) window[i] <= '0;
      hist[0] <= '0;
      hist[1] <= '0;
      pos     <= '0;
    end else begin
      state <= state_next;
      if (state == S_LIN) begin
        for (int i = 0; i < NUM_TAPS-1; i++) window[i] <= window[i+1];
        window[NUM_TAPS-1] <= lin_val;
      end
      if (state == S_EMIT_A && advance && !frame_end_r) begin
        hist[0] <= hist[1];
        hist[1] <= fir_out;
        if (pos != 3'd7) pos <= pos + 3'd1;
      end
      if (state == S_EMIT_C && advance) begin
        for (int i = 0; i < NUM_TAPS; i++) window[i] <= '0;
        hist[0] <= '0;
        hist[1] <= '0;
        pos     <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/tpc_queue.sv =====
module tpc_queue #(
  parameter int DEPTH = tpc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  tpc_pkg::out_word_t push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpc_pkg::out_word_t out_data
);
  import tpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_word_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign out_valid  = (count != '0);
  assign out_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/trigger_primitive_chain.sv =====
// Trigger-primitive chain: linearizer, five-tap FIR, peak finder, strip value.
// Input channel (in_valid/in_ready/in_data) takes one ADC word with its three
// gain coefficients; frame_end marks the last word of a frame.
// Output channel (out_valid/out_ready/out_data) gives one result word per
// frame position, in order, two positions behind the input; the word that
// carries frame_end flushes up to three results, the last with frame_last.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes weight_0..4,
// always ready; the user must write only while the block is idle (unchecked).
// Sequencing: a word goes through the front sequencer's accept, linearize,
// multiply and sum steps, then one emit step when it causes at most one
// result, or emit steps A, B and C on a frame end; in_ready is high only while
// that sequencer is idle. A result enters the output queue in the emit step
// and is shown on out_valid the next cycle.
// Reset clears weights, the sample window, filter history, position count and
// the queue. When the receiver stalls the queue fills, the sequencer holds in
// its emit step and in_ready stays low until space frees.
module trigger_primitive_chain #(
  parameter int QUEUE_DEPTH = tpc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tpc_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tpc_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpc_pkg::WEIGHT_W-1:0]    cfg_data
);
  import tpc_pkg::*;

  logic      push_valid, push_ready;
  out_word_t push_data;

  assign cfg_ready = 1'b1;

  tpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/tpc_checker.sv =====
`include "assert_macros.svh"

module tpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input tpc_pkg::out_word_t              out_data
);
  import tpc_pkg::*;

  // A stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // One word at a time through the front: no accept right after an accept
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // Strip value only at a peak
  `ASSERT_IMPLY(a_strip_peak, clk, rst, out_valid && !out_data.peak_flag,
                out_data.strip_value == '0)

  // Last position of a frame: zero filter value, never a peak
  `ASSERT_IMPLY(a_last_word, clk, rst, out_valid && out_data.frame_last,
                out_data.filter_value == '0 && !out_data.peak_flag)

endmodule

bind trigger_primitive_chain tpc_checker u_tpc_checker (.*);

// ===== tb/sv/tpc_result_check.sv =====
// Watches the input, result and weight channels of the trigger-primitive chain,
// predicts each position's result word and compares it with what comes out.
module tpc_result_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  tpc_pkg::in_word_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  tpc_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpc_pkg::WEIGHT_W-1:0]    cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              peaks
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  localparam logic [1:0] GAIN_1 = 2'd1;
  localparam logic [1:0] GAIN_2 = 2'd2;
  localparam logic [1:0] GAIN_3 = 2'd3;
  localparam logic [COEFF_W-1:0] MULT_MASK  = 24'hFF0000;
  localparam logic [COEFF_W-1:0] FULL_SCALE = 24'hFF0000;

  // Own copy of the weights and of the frame state
  logic signed [WEIGHT_W-1:0] tap_weight [NUM_TAPS];
  logic [LIN_W-1:0]           lin_win [NUM_TAPS];   // [4] newest
  logic [LIN_W-1:0]           filt_hist [2];        // [1] newest
  logic [2:0]                 position;

  out_word_t due_positions [$];
  int        mismatches;
  int        results_seen;
  int        peaks_seen;

  // Gain select, 16-bit wrapping subtract, multiply, shift, clip
  function automatic logic [LIN_W-1:0] linearize_sample(in_word_t w);
    logic [11:0]        raw;
    logic [COEFF_W-1:0] coeff;
    logic [15:0]        diff;
    logic [23:0]        scaled;
    raw = w.adc_word[11:0];
    case (w.adc_word[13:12])
      GAIN_1: coeff = w.coeff_gain1;
      GAIN_2: coeff = w.coeff_gain2;
      GAIN_3: coeff = w.coeff_gain3;
      default: begin
        if (((w.coeff_gain1 | w.coeff_gain2 | w.coeff_gain3) & MULT_MASK) == '0)
          coeff = '0;
        else
          coeff = FULL_SCALE;
      end
    endcase
    diff = {4'b0, raw} - {4'b0, coeff[11:0]};
    scaled = (24'(diff) * 24'(coeff[23:16])) >> (5'(coeff[15:12]) + 5'd2);
    return (scaled > 24'(LIN_MAX)) ? LIN_MAX : scaled[LIN_W-1:0];
  endfunction

  // Five taps, each term floored by >>6, sum clipped to 0..LIN_MAX
  function automatic logic [LIN_W-1:0] fir_sum();
    longint acc;
    longint term;
    acc = 0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      term = longint'(tap_weight[i]) * longint'(lin_win[i]);
      acc += term >>> 6;
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(LIN_MAX)) acc = longint'(LIN_MAX);
    return acc[LIN_W-1:0];
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < NUM_TAPS; i++) lin_win[i] = '0;
    filt_hist[0] = '0;
    filt_hist[1] = '0;
    position = '0;
  endfunction

  function automatic void queue_result(logic [LIN_W-1:0] lin, logic [LIN_W-1:0] filt,
                                       logic pk, logic last);
    out_word_t r;
    r.lin_value    = lin;
    r.filter_value = filt;
    r.peak_flag    = pk;
    r.strip_value  = !pk ? '0 : (filt > 18'(STRIP_MAX)) ? STRIP_MAX : filt[STRIP_W-1:0];
    r.frame_last   = last;
    due_positions.push_back(r);
  endfunction

  // One accepted input word: up to three result words fall due
  function automatic void chain_step(in_word_t w);
    logic [2:0]       n;
    logic [LIN_W-1:0] lin;
    logic [LIN_W-1:0] f;
    logic             pk;
    n = position;
    lin = linearize_sample(w);
    for (int i = 0; i < NUM_TAPS - 1; i++) lin_win[i] = lin_win[i+1];
    lin_win[NUM_TAPS-1] = lin;
    f = (n >= 3'd4) ? fir_sum() : '0;

    if (n >= 3'd2) begin
      pk = (n >= 3'd3) && (filt_hist[1] > filt_hist[0]) && (filt_hist[1] > f);
      queue_result(lin_win[2], filt_hist[1], pk, 1'b0);
    end
    if (w.frame_end) begin
      // flush the rest of the frame and start again
      if (n >= 3'd1) begin
        pk = (n >= 3'd2) && (f > filt_hist[1]) && (f > '0);
        queue_result(lin_win[3], f, pk, 1'b0);
      end
      queue_result(lin_win[4], '0, 1'b0, 1'b1);
      clear_frame();
    end else begin
      filt_hist[0] = filt_hist[1];
      filt_hist[1] = f;
      if (n < 3'd7) position = n + 3'd1;
    end
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) tap_weight[i] = '0;
      clear_frame();
      due_positions.delete();
      mismatches   = 0;
      results_seen = 0;
      peaks_seen   = 0;
    end else begin
      // weight writes
      if (cfg_valid && cfg_ready && cfg_index < NUM_TAPS)
        tap_weight[cfg_index] = cfg_data;

      // result word against the oldest expectation
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_positions.size() == 0) begin
          $error("result word with nothing expected: lin_value 0x%0h", out_data.lin_value);
          mismatches++;
        end else begin
          want = due_positions.pop_front();
          if (want.peak_flag) peaks_seen++;
          check_field("lin_value", want.lin_value, out_data.lin_value);
          check_field("filter_value", want.filter_value, out_data.filter_value);
          check_field("peak_flag", want.peak_flag, out_data.peak_flag);
          check_field("strip_value", want.strip_value, out_data.strip_value);
          check_field("frame_last", want.frame_last, out_data.frame_last);
        end
      end

      if (in_valid && in_ready) chain_step(in_data);
    end
    fail_count <= mismatches;
    pending    <= due_positions.size();
    checked    <= results_seen;
    peaks      <= peaks_seen;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  localparam int STALL_LIMIT   = 1000;  // cycles with no word moving on any channel
  localparam int SETTLE_CYCLES = 20;    // covers a word still in the sequencer
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_WORDS   = 46;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WEIGHT_W-1:0]    cfg_data;

  int   fail_count;
  int   pending;
  int   checked;
  int   peaks;
  logic idle_on;
  int   words_sent;
  int   frames_sent;
  int   settings_used;
  int   target;

  trigger_primitive_chain dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpc_result_check u_result_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .peaks      (peaks)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic in_word_t make_word(logic [ADC_W-1:0] adc, logic [COEFF_W-1:0] c1,
                                         logic [COEFF_W-1:0] c2, logic [COEFF_W-1:0] c3,
                                         logic fe);
    in_word_t w;
    w.adc_word    = adc;
    w.coeff_gain1 = c1;
    w.coeff_gain2 = c2;
    w.coeff_gain3 = c3;
    w.frame_end   = fe;
    return w;
  endfunction

  // Gain identifier for the top two bits of an ADC word
  function automatic logic [1:0] GAIN_BITS(int g);
    return 2'(g);
  endfunction

  // Calibrated coefficient, or raw noise with the occasional zero multiplier
  function automatic logic [COEFF_W-1:0] rand_coeff(bit noisy);
    if (!noisy)
      return {8'($urandom_range(1, 255)), 4'($urandom_range(0, 6)),
              12'($urandom_range(0, 511))};
    if ($urandom_range(0, 3) == 0)
      return {8'h00, 16'($urandom())};
    return 24'($urandom());
  endfunction

  // Offer one word, with a random gap first while idling is on
  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_frame(int len, bit noisy);
    logic [COEFF_W-1:0] c1;
    logic [COEFF_W-1:0] c2;
    logic [COEFF_W-1:0] c3;
    c1 = rand_coeff(noisy);
    c2 = rand_coeff(noisy);
    c3 = rand_coeff(noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        c1 = rand_coeff(1'b1);
        c2 = rand_coeff(1'b1);
        c3 = rand_coeff(1'b1);
      end
      send_word(make_word(ADC_W'($urandom()), c1, c2, c3, i == len - 1));
    end
    frames_sent++;
  endtask

  // Hold off the sender until every result has come, then let the block settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five weights, weight_0 first
  task automatic set_weights(int w0, int w1, int w2, int w3, int w4);
    logic [NUM_TAPS-1:0][WEIGHT_W-1:0] w;
    w = {7'(w4), 7'(w3), 7'(w2), 7'(w1), 7'(w0)};
    for (int i = 0; i < NUM_TAPS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_WEIGHT_0 + CFG_INDEX_W'(i);
      cfg_data  <= w[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Receiver: ready runs broken by random stalls while idling is on
  initial begin
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles where no word moves
  initial begin
    int quiet;
    quiet = 0;
    wait (rst == 1'b0);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    idle_on       = 1'b0;
    words_sent    = 0;
    frames_sent   = 0;
    settings_used = 0;
    repeat (7) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;
    @(posedge clk);

    // Reset weights: one-word frame with zero gain coefficient, then a two-word
    // frame ending on gain zero at full scale
    send_word(make_word(14'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b1));
    send_word(make_word(14'h3FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    send_word(make_word(14'h0FFF, 24'h010000, 24'h000000, 24'h000000, 1'b1));
    frames_sent += 2;
    drain_and_settle();

    // Newest tap only, so the filter follows the samples: a peak inside the
    // frame and one found on the flush
    set_weights(0, 0, 0, 0, 63);
    send_word(make_word({GAIN_BITS(1), 12'd100}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd400}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd200}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd800}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd300}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd900}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd100}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd500}, 24'h100000, '0, '0, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'd700}, 24'h100000, '0, '0, 1'b1));
    frames_sent++;

    // Field extremes: base above the count, shift 15, multiplier 255, the
    // linearizer clip and a strip value past its saturation point
    send_word(make_word({GAIN_BITS(2), 12'h000}, 24'h000000, 24'hFF0001, 24'h000000, 1'b0));
    send_word(make_word({GAIN_BITS(3), 12'hFFF}, 24'h000000, 24'h000000, 24'hFFF000, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'h800}, 24'hFF0000, 24'h000000, 24'h000000, 1'b0));
    send_word(make_word({GAIN_BITS(0), 12'hABC}, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'hFFF}, 24'hFF0000, 24'h000000, 24'h000000, 1'b0));
    send_word(make_word({GAIN_BITS(0), 12'h000}, 24'h000000, 24'h000000, 24'h000000, 1'b0));
    send_word(make_word({GAIN_BITS(2), 12'h001}, 24'h000000, 24'h80F7FF, 24'h000000, 1'b0));
    send_word(make_word({GAIN_BITS(3), 12'hFFF}, 24'h000000, 24'h000000, 24'hFF0FFF, 1'b0));
    send_word(make_word({GAIN_BITS(0), 12'hFFF}, 24'h000000, 24'h000000, 24'h800000, 1'b0));
    send_word(make_word({GAIN_BITS(1), 12'h123}, 24'h7F2040, 24'h000000, 24'h000000, 1'b1));
    frames_sent++;
    drain_and_settle();

    // Random frames, one weight setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_weights(63, 63, 63, 63, 63);
        1: set_weights(-64, -64, -64, -64, -64);
        2: set_weights(4, 16, 24, 16, 4);
        3: set_weights(-8, 16, 40, 16, -8);
        4, 5: set_weights($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom_range(0, 63));
        6: set_weights(int'($urandom_range(0, 127)) - 64, int'($urandom_range(0, 127)) - 64,
                       int'($urandom_range(0, 127)) - 64, int'($urandom_range(0, 127)) - 64,
                       int'($urandom_range(0, 127)) - 64);
        default: set_weights(0, 8, 48, 8, 0);
      endcase
      // one calm phase mid-run, and none at all at the end
      idle_on <= (p != 2) && (p != NUM_PHASES - 1);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        case ($urandom_range(0, 7))
          0:       send_frame($urandom_range(1, 2), $urandom_range(0, 1) == 1);
          1:       send_frame($urandom_range(13, 24), $urandom_range(0, 3) == 0);
          default: send_frame($urandom_range(3, 12), $urandom_range(0, 3) == 0);
        endcase
      end
      drain_and_settle();
    end

    $display("Sent %0d input words in %0d frames across %0d weight settings.",
             words_sent, frames_sent, settings_used);
    $display("Checked %0d result words, %0d of them at peaks.", checked, peaks);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
